>>> rtl/mitp_pkg.sv
package mitp_pkg;

  localparam int unsigned CONSUMED_MAX_DEF = 255;

  localparam logic [31:0] DEC_LIMIT   = 32'd429496729;
  localparam logic [31:0] HEX_TOP     = 32'hf0000000;
  localparam logic [31:0] OCT_TOP     = 32'he0000000;
  localparam logic [31:0] SIGN_BIT    = 32'h80000000;

  localparam logic [4:0]  NO_DIGIT    = 5'd16;

  localparam logic [1:0]  ST_OK       = 2'd0;
  localparam logic [1:0]  ST_NONUM    = 2'd1;
  localparam logic [1:0]  ST_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_SKIP1 = 4'd1,
    PH_SKIP2 = 4'd2,
    PH_ZERO  = 4'd3,
    PH_HEX0  = 4'd4,
    PH_BIN0  = 4'd5,
    PH_DEC   = 4'd6,
    PH_HEX   = 4'd7,
    PH_OCT   = 4'd8,
    PH_BIN   = 4'd9,
    PH_DONE  = 4'd10
  } phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       mode;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [7:0]  consumed;
    logic [7:0]  stop_char;
  } out_t;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

>>> rtl/mitp_in_reg.sv
module mitp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mitp_pkg::in_t  in_data_i,
  input  logic           fire_i,
  output logic           held_valid_o,
  output mitp_pkg::in_t  held_data_o
);

  logic          valid_q, valid_d;
  mitp_pkg::in_t data_q;
  logic          take;

  assign in_stall_o   = valid_q && !fire_i;
  assign take         = in_valid_i && !in_stall_o;
  assign held_valid_o = valid_q;
  assign held_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i;
    end
  end

endmodule

>>> rtl/mitp_core.sv
module mitp_core #(
  parameter int unsigned CONSUMED_MAX = mitp_pkg::CONSUMED_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  mitp_pkg::in_t  item_i,
  output logic           res_valid_o,
  output mitp_pkg::out_t res_o
);

  localparam int unsigned CW = $clog2(CONSUMED_MAX + 1);

  mitp_pkg::phase_e phase_q, phase_d, ph_e;
  logic [31:0]      acc_q, acc_d, acc_e;
  logic             neg_q, neg_d, neg_e;
  logic             sgn_q, sgn_d, sgn_e;
  logic [CW-1:0]    cnt_q, cnt_d, cnt_e, cnt_inc;
  logic [CW+7:0]    cnt_ext;
  logic [7:0]       ch;
  logic [4:0]       d;
  logic [31:0]      acc_dec;

  assign ch      = item_i.ch;
  assign d       = mitp_pkg::digit_of(ch);
  assign cnt_inc = (cnt_e < CW'(CONSUMED_MAX)) ? cnt_e + 1'b1 : cnt_e;
  assign cnt_ext = {8'b0, cnt_e};
  assign acc_dec = {acc_e[28:0], 3'b0} + {acc_e[30:0], 1'b0} + {28'b0, d[3:0]};

  always_comb begin
    if (item_i.first) begin
      ph_e  = mitp_pkg::PH_SKIP1;
      acc_e = '0;
      neg_e = 1'b0;
      sgn_e = item_i.mode;
      cnt_e = '0;
    end else begin
      ph_e  = phase_q;
      acc_e = acc_q;
      neg_e = neg_q;
      sgn_e = sgn_q;
      cnt_e = cnt_q;
    end

    phase_d     = ph_e;
    acc_d       = acc_e;
    neg_d       = neg_e;
    sgn_d       = sgn_e;
    cnt_d       = cnt_e;
    res_valid_o = 1'b0;
    res_o.value     = '0;
    res_o.status    = mitp_pkg::ST_NONUM;
    res_o.consumed  = '0;
    res_o.stop_char = ch;

    unique case (ph_e)
      mitp_pkg::PH_SKIP1, mitp_pkg::PH_SKIP2: begin
        if (ch >= 8'd1 && ch <= 8'd32) begin
          cnt_d = cnt_inc;
        end else if (ch == 8'h2d && sgn_e && ph_e == mitp_pkg::PH_SKIP1) begin
          neg_d   = 1'b1;
          cnt_d   = cnt_inc;
          phase_d = mitp_pkg::PH_SKIP2;
        end else if (ch == 8'h30) begin
          acc_d   = '0;
          cnt_d   = cnt_inc;
          phase_d = mitp_pkg::PH_ZERO;
        end else if (ch == 8'h62 || ch == 8'h42) begin
          cnt_d   = cnt_inc;
          phase_d = mitp_pkg::PH_BIN0;
        end else if (ch >= 8'h31 && ch <= 8'h39) begin
          acc_d   = {27'b0, d};
          cnt_d   = cnt_inc;
          phase_d = mitp_pkg::PH_DEC;
        end else begin
          res_valid_o = 1'b1;
          phase_d     = mitp_pkg::PH_DONE;
        end
      end
      mitp_pkg::PH_ZERO: begin
        if (ch == 8'h78 || ch == 8'h58) begin
          cnt_d   = cnt_inc;
          phase_d = mitp_pkg::PH_HEX0;
        end else if (d < 5'd8) begin
          acc_d   = {27'b0, d};
          cnt_d   = cnt_inc;
          phase_d = mitp_pkg::PH_OCT;
        end else begin
          acc_d          = '0;
          res_valid_o    = 1'b1;
          phase_d        = mitp_pkg::PH_DONE;
          res_o.status   = mitp_pkg::ST_OK;
          res_o.consumed = cnt_ext[7:0];
        end
      end
      mitp_pkg::PH_HEX0, mitp_pkg::PH_BIN0: begin
        if ((ph_e == mitp_pkg::PH_HEX0 && d < 5'd16) ||
            (ph_e == mitp_pkg::PH_BIN0 && d < 5'd2)) begin
          acc_d   = {27'b0, d};
          cnt_d   = cnt_inc;
          phase_d = (ph_e == mitp_pkg::PH_HEX0) ? mitp_pkg::PH_HEX : mitp_pkg::PH_BIN;
        end else begin
          res_valid_o = 1'b1;
          phase_d     = mitp_pkg::PH_DONE;
        end
      end
      mitp_pkg::PH_DEC, mitp_pkg::PH_HEX, mitp_pkg::PH_OCT, mitp_pkg::PH_BIN: begin
        if ((ph_e == mitp_pkg::PH_DEC && d < 5'd10) ||
            (ph_e == mitp_pkg::PH_HEX && d < 5'd16) ||
            (ph_e == mitp_pkg::PH_OCT && d < 5'd8) ||
            (ph_e == mitp_pkg::PH_BIN && d < 5'd2)) begin
          if ((ph_e == mitp_pkg::PH_DEC && (acc_e > mitp_pkg::DEC_LIMIT ||
               (acc_e == mitp_pkg::DEC_LIMIT && d > 5'd5))) ||
              (ph_e == mitp_pkg::PH_HEX && (acc_e & mitp_pkg::HEX_TOP) != '0) ||
              (ph_e == mitp_pkg::PH_OCT && (acc_e & mitp_pkg::OCT_TOP) != '0) ||
              (ph_e == mitp_pkg::PH_BIN && (acc_e & mitp_pkg::SIGN_BIT) != '0)) begin
            res_valid_o  = 1'b1;
            phase_d      = mitp_pkg::PH_DONE;
            res_o.status = mitp_pkg::ST_OVERFLOW;
          end else begin
            cnt_d = cnt_inc;
            unique case (ph_e)
              mitp_pkg::PH_DEC: acc_d = acc_dec;
              mitp_pkg::PH_HEX: acc_d = {acc_e[27:0], d[3:0]};
              mitp_pkg::PH_OCT: acc_d = {acc_e[28:0], d[2:0]};
              default:          acc_d = {acc_e[30:0], d[0]};
            endcase
          end
        end else begin
          res_valid_o = 1'b1;
          phase_d     = mitp_pkg::PH_DONE;
          if (sgn_e && acc_e[31]) begin
            res_o.status = mitp_pkg::ST_OVERFLOW;
          end else begin
            res_o.status   = mitp_pkg::ST_OK;
            res_o.value    = neg_e ? (~acc_e + 32'd1) : acc_e;
            res_o.consumed = cnt_ext[7:0];
          end
        end
      end
      default: begin
        phase_d = ph_e;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mitp_pkg::PH_IDLE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      sgn_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      sgn_q   <= sgn_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/mitp_out_reg.sv
module mitp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  mitp_pkg::out_t res_i,
  input  logic           held_valid_i,
  output logic           fire_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mitp_pkg::out_t out_data_o
);

  logic           valid_q, valid_d;
  mitp_pkg::out_t data_q;
  logic           load;

  assign fire_o      = held_valid_i && (!valid_q || !out_stall_i);
  assign load        = fire_o && res_valid_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

endmodule

>>> rtl/multibase_integer_text_parser.sv
// A word is held in the input register; its result goes into the output register.
// Throughput: one word per cycle unless stalled; the parse state advances in one step.
// A word that ends a token leaves through the output register, which holds under stall.
// Reset: asynchronous, active low; parser returns to idle, both registers empty,
// characters without the first flag are then dropped.
module multibase_integer_text_parser #(
  parameter int unsigned CONSUMED_MAX = mitp_pkg::CONSUMED_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mitp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mitp_pkg::out_t out_data_o
);

  logic           fire;
  logic           held_valid;
  mitp_pkg::in_t  held_data;
  logic           res_valid;
  mitp_pkg::out_t res;

  mitp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .fire_i       (fire),
    .held_valid_o (held_valid),
    .held_data_o  (held_data)
  );

  mitp_core #(
    .CONSUMED_MAX (CONSUMED_MAX)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (held_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mitp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .held_valid_i (held_valid),
    .fire_o       (fire),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
